// File: rtl/core/ter_pkg.sv
// ----------------------------------------------------------------------------
// Trimmed elevation range package
// Shared constants and types for the front end, job queue and selector.
// ----------------------------------------------------------------------------
package ter_pkg;

  localparam int MAX_SAMPLES = 8192;
  localparam int ELEV_BITS   = 32;
  localparam int MAG_W       = ELEV_BITS - 1;
  localparam int ADDR_W      = $clog2(MAX_SAMPLES);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int STRIDE_W    = 12;
  localparam int TAIL_W      = 15;
  localparam int PROD_W      = CNT_W + TAIL_W;
  localparam int BAND_W      = PROD_W - 16;
  localparam int APB_AW      = 4;
  localparam int APB_DW      = 32;

  localparam logic [1:0] REG_STRIDE = 2'd0;
  localparam logic [1:0] REG_TAIL   = 2'd1;
  localparam logic [1:0] REG_GLOW   = 2'd2;
  localparam logic [1:0] REG_GHIGH  = 2'd3;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [MAG_W-1:0]  data;
  } wr_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             ovf;
  } job_t;

endpackage

// File: rtl/core/ter_front.sv
// ----------------------------------------------------------------------------
// Trimmed elevation range front end
// Tracks row and column phase, keeps positive samples and posts frame jobs.
// ----------------------------------------------------------------------------
module ter_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          fire_i,
  input  logic [ter_pkg::ELEV_BITS-1:0] elevation_i,
  input  logic                          end_of_row_i,
  input  logic                          end_of_frame_i,
  input  logic [ter_pkg::STRIDE_W-1:0]  stride_i,
  output ter_pkg::wr_t                  wr_o,
  output logic                          job_push_o,
  output ter_pkg::job_t                 job_o
);

  logic [ter_pkg::STRIDE_W-1:0] col_q, col_d, row_q, row_d, stride_eff;
  logic [ter_pkg::CNT_W-1:0]    count_q, count_d;
  logic                         ovf_q, ovf_d;
  logic                         sample, room;

  function automatic logic [ter_pkg::STRIDE_W-1:0] next_phase(
    input logic [ter_pkg::STRIDE_W-1:0] phase,
    input logic [ter_pkg::STRIDE_W-1:0] stride
  );
    logic [ter_pkg::STRIDE_W:0] p1;
    p1 = {1'b0, phase} + 1'b1;
    return (p1 >= {1'b0, stride}) ? '0 : p1[ter_pkg::STRIDE_W-1:0];
  endfunction

  assign stride_eff = (stride_i == '0) ? ter_pkg::STRIDE_W'(1) : stride_i;
  assign sample = fire_i && (row_q == '0) && (col_q == '0) &&
                  !elevation_i[ter_pkg::ELEV_BITS-1] && (elevation_i != '0);
  assign room   = count_q < ter_pkg::CNT_W'(ter_pkg::MAX_SAMPLES);

  assign wr_o.en   = sample && room;
  assign wr_o.addr = count_q[ter_pkg::ADDR_W-1:0];
  assign wr_o.data = elevation_i[ter_pkg::MAG_W-1:0];

  always_comb begin
    count_d = (sample && room) ? count_q + 1'b1 : count_q;
    ovf_d   = ovf_q | (sample & ~room);
    col_d   = col_q;
    row_d   = row_q;
    if (fire_i) begin
      if (end_of_row_i || end_of_frame_i) begin
        col_d = '0;
        row_d = next_phase(row_q, stride_eff);
      end else begin
        col_d = next_phase(col_q, stride_eff);
      end
    end
  end

  assign job_push_o  = fire_i && end_of_frame_i;
  assign job_o.count = count_d;
  assign job_o.ovf   = ovf_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else if (job_push_o) begin
      col_q   <= '0;
      row_q   <= '0;
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

endmodule

// File: rtl/core/ter_job_fifo.sv
// ----------------------------------------------------------------------------
// Trimmed elevation range job queue
// Two-entry queue of finished frames between front end and selector.
// ----------------------------------------------------------------------------
module ter_job_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ter_pkg::job_t push_data_i,
  input  logic          pop_i,
  output logic          valid_o,
  output ter_pkg::job_t pop_data_o
);

  ter_pkg::job_t mem_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    fill_q;

  assign valid_o    = fill_q != 2'd0;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i && valid_o) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      fill_q <= fill_q + {1'b0, push_i} - {1'b0, pop_i && valid_o};
    end
  end

endmodule

// File: rtl/core/ter_back.sv
// ----------------------------------------------------------------------------
// Trimmed elevation range selector
// Holds the sample memory and finds both trimmed order statistics by a
// bitwise radix search, one memory pass per magnitude bit.
// ----------------------------------------------------------------------------
module ter_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ter_pkg::wr_t                  wr_i,
  input  logic                          job_valid_i,
  input  ter_pkg::job_t                 job_i,
  output logic                          job_pop_o,
  input  logic [ter_pkg::TAIL_W-1:0]    tail_i,
  input  logic [ter_pkg::ELEV_BITS-1:0] given_low_i,
  input  logic [ter_pkg::ELEV_BITS-1:0] given_high_i,
  output logic                          mem_busy_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ter_pkg::ELEV_BITS-1:0] low_elevation_o,
  output logic [ter_pkg::ELEV_BITS-1:0] high_elevation_o,
  output logic                          range_found_o,
  output logic [ter_pkg::CNT_W-1:0]     kept_count_o,
  output logic                          store_overflow_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_PREP, ST_SCAN, ST_STEP, ST_FIN
  } state_e;

  state_e                      state_q;
  logic [ter_pkg::MAG_W-1:0]   mem [ter_pkg::MAX_SAMPLES];
  logic [ter_pkg::MAG_W-1:0]   rdata_q;
  logic                        rvalid_q;
  logic [ter_pkg::CNT_W-1:0]   n_q, cnt_q, rank_lo_q, rank_hi_q, c_lo_q, c_hi_q;
  logic                        ovf_q;
  logic [ter_pkg::PROD_W-1:0]  prod_q;
  logic [ter_pkg::BAND_W-1:0]  band;
  logic [ter_pkg::MAG_W-1:0]   pref_lo_q, pref_hi_q, mask_q, bsel_q;
  logic [ter_pkg::ELEV_BITS-1:0] lo_q, hi_q;
  logic                        found_q;
  logic                        issue, hit_lo, hit_hi, given;

  assign band  = prod_q[ter_pkg::PROD_W-1:16];
  assign issue = (state_q == ST_SCAN) && (cnt_q < n_q);
  assign given = $signed(given_high_i) > $signed(given_low_i);
  assign hit_lo = rvalid_q && (((rdata_q ^ pref_lo_q) & mask_q) == '0) &&
                  ((rdata_q & bsel_q) == '0);
  assign hit_hi = rvalid_q && (((rdata_q ^ pref_hi_q) & mask_q) == '0) &&
                  ((rdata_q & bsel_q) == '0);

  assign job_pop_o  = (state_q == ST_IDLE) && job_valid_i;
  assign mem_busy_o = (state_q != ST_IDLE) && (state_q != ST_FIN);

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (issue) begin
      rdata_q <= mem[cnt_q[ter_pkg::ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rvalid_q    <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      rvalid_q <= issue;
      if (out_valid_o && out_ready_i && (state_q != ST_FIN)) begin
        out_valid_o <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (job_valid_i) begin
            n_q     <= job_i.count;
            ovf_q   <= job_i.ovf;
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod_q  <= n_q * tail_i;
          state_q <= ST_PREP;
        end
        ST_PREP: begin
          if (given) begin
            lo_q    <= given_low_i;
            hi_q    <= given_high_i;
            found_q <= 1'b1;
            state_q <= ST_FIN;
          end else if ({band, 1'b0} >= n_q) begin
            lo_q    <= '0;
            hi_q    <= '0;
            found_q <= 1'b0;
            state_q <= ST_FIN;
          end else begin
            rank_lo_q <= ter_pkg::CNT_W'(band);
            rank_hi_q <= n_q - 1'b1 - ter_pkg::CNT_W'(band);
            pref_lo_q <= '0;
            pref_hi_q <= '0;
            mask_q    <= '0;
            bsel_q    <= {1'b1, {(ter_pkg::MAG_W-1){1'b0}}};
            cnt_q     <= '0;
            c_lo_q    <= '0;
            c_hi_q    <= '0;
            state_q   <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (issue) begin
            cnt_q <= cnt_q + 1'b1;
          end
          if (hit_lo) begin
            c_lo_q <= c_lo_q + 1'b1;
          end
          if (hit_hi) begin
            c_hi_q <= c_hi_q + 1'b1;
          end
          if (!issue && !rvalid_q) begin
            state_q <= ST_STEP;
          end
        end
        ST_STEP: begin
          if (rank_lo_q >= c_lo_q) begin
            pref_lo_q <= pref_lo_q | bsel_q;
            rank_lo_q <= rank_lo_q - c_lo_q;
          end
          if (rank_hi_q >= c_hi_q) begin
            pref_hi_q <= pref_hi_q | bsel_q;
            rank_hi_q <= rank_hi_q - c_hi_q;
          end
          cnt_q  <= '0;
          c_lo_q <= '0;
          c_hi_q <= '0;
          mask_q <= mask_q | bsel_q;
          bsel_q <= bsel_q >> 1;
          if (bsel_q[0]) begin
            found_q <= 1'b1;
            state_q <= ST_FIN;
          end else begin
            state_q <= ST_SCAN;
          end
        end
        ST_FIN: begin
          if (bsel_q == '0 && found_q && !given) begin
            lo_q <= {1'b0, pref_lo_q};
            hi_q <= {1'b0, pref_hi_q};
          end
          if (!out_valid_o || out_ready_i) begin
            low_elevation_o  <= (bsel_q == '0 && found_q && !given) ?
                                {1'b0, pref_lo_q} : lo_q;
            high_elevation_o <= (bsel_q == '0 && found_q && !given) ?
                                {1'b0, pref_hi_q} : hi_q;
            range_found_o    <= found_q;
            kept_count_o     <= n_q;
            store_overflow_o <= ovf_q;
            out_valid_o      <= 1'b1;
            bsel_q           <= {1'b1, {(ter_pkg::MAG_W-1){1'b0}}};
            state_q          <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/core/trimmed_elevation_range_core.sv
// ----------------------------------------------------------------------------
// Trimmed elevation range core
// Register file, front end, job queue and radix selector.
// ----------------------------------------------------------------------------
// Pixels are taken at one beat per cycle while a frame streams in. At the end
// of a frame the selector searches the stored samples bit by bit, one full
// read of the sample memory per magnitude bit through the single read port
// of the memory. While that search runs the input is held off; the result
// beat comes from an output register and can wait for its consumer.
module trimmed_elevation_range_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [ter_pkg::ELEV_BITS-1:0] elevation_i,
  input  logic                          end_of_row_i,
  input  logic                          end_of_frame_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ter_pkg::ELEV_BITS-1:0] low_elevation_o,
  output logic [ter_pkg::ELEV_BITS-1:0] high_elevation_o,
  output logic                          range_found_o,
  output logic [ter_pkg::CNT_W-1:0]     kept_count_o,
  output logic                          store_overflow_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ter_pkg::APB_AW-1:0]    paddr,
  input  logic [ter_pkg::APB_DW-1:0]    pwdata,
  output logic [ter_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);

  logic [ter_pkg::STRIDE_W-1:0]  stride_q;
  logic [ter_pkg::TAIL_W-1:0]    tail_q;
  logic [ter_pkg::ELEV_BITS-1:0] glow_q, ghigh_q;
  logic [1:0]                    reg_idx;
  logic                          wr_en, fire, job_push, job_pop, job_valid, mem_busy;
  ter_pkg::wr_t                  wr;
  ter_pkg::job_t                 job_in, job_out;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stride_q <= ter_pkg::STRIDE_W'(1);
      tail_q   <= ter_pkg::TAIL_W'(1638);
      glow_q   <= '0;
      ghigh_q  <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        ter_pkg::REG_STRIDE: stride_q <= pwdata[ter_pkg::STRIDE_W-1:0];
        ter_pkg::REG_TAIL:   tail_q   <= pwdata[ter_pkg::TAIL_W-1:0];
        ter_pkg::REG_GLOW:   glow_q   <= pwdata;
        ter_pkg::REG_GHIGH:  ghigh_q  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      ter_pkg::REG_STRIDE: prdata = ter_pkg::APB_DW'(stride_q);
      ter_pkg::REG_TAIL:   prdata = ter_pkg::APB_DW'(tail_q);
      ter_pkg::REG_GLOW:   prdata = glow_q;
      ter_pkg::REG_GHIGH:  prdata = ghigh_q;
      default:             prdata = '0;
    endcase
  end

  assign in_ready_o = !(job_valid || mem_busy);
  assign fire       = in_valid_i && in_ready_o;

  ter_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .elevation_i   (elevation_i),
    .end_of_row_i  (end_of_row_i),
    .end_of_frame_i(end_of_frame_i),
    .stride_i      (stride_q),
    .wr_o          (wr),
    .job_push_o    (job_push),
    .job_o         (job_in)
  );

  ter_job_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (job_push),
    .push_data_i(job_in),
    .pop_i      (job_pop),
    .valid_o    (job_valid),
    .pop_data_o (job_out)
  );

  ter_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .wr_i            (wr),
    .job_valid_i     (job_valid),
    .job_i           (job_out),
    .job_pop_o       (job_pop),
    .tail_i          (tail_q),
    .given_low_i     (glow_q),
    .given_high_i    (ghigh_q),
    .mem_busy_o      (mem_busy),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .low_elevation_o (low_elevation_o),
    .high_elevation_o(high_elevation_o),
    .range_found_o   (range_found_o),
    .kept_count_o    (kept_count_o),
    .store_overflow_o(store_overflow_o)
  );

endmodule

// File: rtl/core/ter_checker.sv
// ----------------------------------------------------------------------------
// Trimmed elevation range checker
// Port-level properties of the result channel, bound to the core.
// ----------------------------------------------------------------------------
module ter_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [ter_pkg::ELEV_BITS-1:0] low_elevation_o,
  input logic [ter_pkg::ELEV_BITS-1:0] high_elevation_o,
  input logic                          range_found_o,
  input logic [ter_pkg::CNT_W-1:0]     kept_count_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(low_elevation_o))
    else $error("result beat changed while stalled");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !range_found_o |-> low_elevation_o == '0 && high_elevation_o == '0)
    else $error("missing range carries nonzero bounds");

  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && range_found_o |->
      $signed(low_elevation_o) <= $signed(high_elevation_o))
    else $error("range bounds out of order");

  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> kept_count_o <= ter_pkg::CNT_W'(ter_pkg::MAX_SAMPLES))
    else $error("kept count beyond store size");

endmodule

bind trimmed_elevation_range_core ter_checker u_ter_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .low_elevation_o (low_elevation_o),
  .high_elevation_o(high_elevation_o),
  .range_found_o   (range_found_o),
  .kept_count_o    (kept_count_o)
);
